// ===== design/xmlas_pkg.sv =====
// Package for the XML attribute list scanner: scanner state, result kinds,
// character codes and the context and result structures shared by the modules.
// Depends on nothing.
`default_nettype none

package xmlas_pkg;

    localparam int MAX_ATTRS = 64;
    localparam int COUNT_W = 7;
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        COUNT_W'((MAX_ATTRS > COUNT_MAX) ? COUNT_MAX : MAX_ATTRS);

    localparam int POS_W = 16;

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BETWEEN,
        ST_NAME,
        ST_QUOTE,
        ST_VALUE
    } t_scan_state;

    typedef enum logic [2:0] {
        K_PENDING,
        K_ATTR,
        K_DONE,
        K_NOQUOTE,
        K_UNTERM
    } t_kind;

    typedef struct packed {
        t_scan_state        state;
        logic               quote_single;
        logic [POS_W-1:0]   name_first;
        logic [POS_W-1:0]   name_last;
        logic [POS_W-1:0]   value_first;
        logic [COUNT_W-1:0] count;
    } t_scan_ctx;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   name_first;
        logic [POS_W-1:0]   name_last;
        logic [POS_W-1:0]   value_first;
        logic [POS_W-1:0]   value_last;
        logic [COUNT_W-1:0] attr_count;
        logic [POS_W:0]     err_offset;
    } t_scan_res;

endpackage

`default_nettype wire

// ===== design/xml_attribute_list_scanner.sv =====
// Each accepted byte goes into the input register, its result into the result
// register. One byte per cycle is taken while the output does not stall; the scanner
// context is updated as each byte passes from the input register to the result register.
// Reset (synchronous, active low) empties both registers and leaves the scanner
// finished and idle with a zero attribute count.
// Depends on xmlas_pkg and xmlas_step.
`default_nettype none

module xml_attribute_list_scanner
    import xmlas_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire [7:0]          i_ch,
    input  wire [POS_W-1:0]    i_pos,
    input  wire [POS_W-1:0]    i_tag_end,
    input  wire                i_first,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [2:0]         o_kind,
    output logic [POS_W-1:0]   o_name_first,
    output logic [POS_W-1:0]   o_name_last,
    output logic [POS_W-1:0]   o_value_first,
    output logic [POS_W-1:0]   o_value_last,
    output logic [COUNT_W-1:0] o_attr_count,
    output logic [POS_W:0]     o_err_offset
);

    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_tag_end;
    logic             r_first;

    t_scan_ctx r_ctx;
    t_scan_ctx n_ctx;
    t_scan_res n_res;
    t_scan_res r_res;
    logic      r_out_valid;

    logic move;
    logic in_take;

    assign move = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign in_take = i_in_valid && !o_in_stall;

    xmlas_step u_step (
        .i_ctx     (r_ctx),
        .i_ch      (r_ch),
        .i_pos     (r_pos),
        .i_tag_end (r_tag_end),
        .i_first   (r_first),
        .o_ctx     (n_ctx),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch <= i_ch;
            r_pos <= i_pos;
            r_tag_end <= i_tag_end;
            r_first <= i_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx <= '{state: ST_IDLE, default: '0};
        end else if (move) begin
            r_ctx <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind = r_res.kind;
    assign o_name_first = r_res.name_first;
    assign o_name_last = r_res.name_last;
    assign o_value_first = r_res.value_first;
    assign o_value_last = r_res.value_last;
    assign o_attr_count = r_res.attr_count;
    assign o_err_offset = r_res.err_offset;

endmodule

`default_nettype wire

// ===== design/xmlas_step.sv =====
// Next-state and result logic of the attribute list scanner for one byte.
// Depends on xmlas_pkg.
`default_nettype none

module xmlas_step
    import xmlas_pkg::*;
(
    input  var t_scan_ctx        i_ctx,
    input  wire [7:0]            i_ch,
    input  wire [POS_W-1:0]      i_pos,
    input  wire [POS_W-1:0]      i_tag_end,
    input  wire                  i_first,
    output t_scan_ctx            o_ctx,
    output t_scan_res            o_res
);

    always_comb begin
        t_scan_ctx      c;
        t_scan_res      r;
        logic           consumed;
        logic           is_space;
        logic [POS_W:0] pos_inc;
        logic [7:0]     close_quote;

        c = i_ctx;
        r = '0;
        r.kind = K_PENDING;
        consumed = 1'b0;
        pos_inc = {1'b0, i_pos} + (POS_W+1)'(1);
        is_space = (i_ch == CH_SP) || (i_ch == CH_TAB) || (i_ch == CH_CR) || (i_ch == CH_LF);
        close_quote = c.quote_single ? CH_APOS : CH_QUOT;

        if (i_first) begin
            c.count = '0;
            c.state = ST_BETWEEN;
        end

        unique case (c.state)
            ST_BETWEEN: begin
                if (is_space) begin
                    consumed = 1'b1;
                end else if (i_ch == CH_GT
                             || (i_ch == CH_SLASH && pos_inc == {1'b0, i_tag_end})) begin
                    r.kind = K_DONE;
                    c.state = ST_IDLE;
                end else begin
                    c.name_first = i_pos;
                    c.name_last = i_pos;
                    c.state = (i_ch == CH_EQ) ? ST_QUOTE : ST_NAME;
                    consumed = 1'b1;
                end
            end
            ST_NAME: begin
                if (i_ch == CH_EQ) begin
                    c.state = ST_QUOTE;
                end else begin
                    c.name_last = i_pos;
                end
                consumed = 1'b1;
            end
            ST_QUOTE: begin
                if (i_ch == CH_QUOT || i_ch == CH_APOS) begin
                    c.quote_single = (i_ch == CH_APOS);
                    c.value_first = i_pos;
                    c.state = ST_VALUE;
                    consumed = 1'b1;
                end else begin
                    r.kind = K_NOQUOTE;
                    r.err_offset = {1'b0, i_pos};
                    c.state = ST_IDLE;
                end
            end
            ST_VALUE: begin
                if (i_ch == close_quote) begin
                    r.kind = K_ATTR;
                    r.name_first = c.name_first;
                    r.name_last = c.name_last;
                    r.value_first = c.value_first;
                    r.value_last = i_pos;
                    if (c.count < COUNT_LIMIT) begin
                        c.count = c.count + COUNT_W'(1);
                    end
                    c.state = ST_BETWEEN;
                end
                consumed = 1'b1;
            end
            default: begin
                c.state = ST_IDLE;
            end
        endcase

        if (consumed && pos_inc > {1'b0, i_tag_end}) begin
            r.kind = K_UNTERM;
            r.name_first = '0;
            r.name_last = '0;
            r.value_first = '0;
            r.value_last = '0;
            r.err_offset = pos_inc;
            c.state = ST_IDLE;
        end

        r.attr_count = c.count;
        o_ctx = c;
        o_res = r;
    end

endmodule

`default_nettype wire

// ===== dv/xmlas_span_check.sv =====
// Watches both channels of the XML attribute list scanner, predicts the result of
// every accepted byte and compares it field by field with the block's output.
// Depends on xmlas_pkg.
`timescale 1ns / 1ps

module xmlas_span_check
    import xmlas_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_stall,
    input  wire [7:0]          i_ch,
    input  wire [POS_W-1:0]    i_pos,
    input  wire [POS_W-1:0]    i_tag_end,
    input  wire                i_first,
    input  wire                i_out_valid,
    input  wire                i_out_stall,
    input  wire [2:0]          i_kind,
    input  wire [POS_W-1:0]    i_name_first,
    input  wire [POS_W-1:0]    i_name_last,
    input  wire [POS_W-1:0]    i_value_first,
    input  wire [POS_W-1:0]    i_value_last,
    input  wire [COUNT_W-1:0]  i_attr_count,
    input  wire [POS_W:0]      i_err_offset,
    output int                 o_fail_count,
    output int                 o_waiting
);

    t_scan_state        st = ST_IDLE;
    logic               quote_single = 1'b0;
    logic [POS_W-1:0]   nm_first = '0;
    logic [POS_W-1:0]   nm_last = '0;
    logic [POS_W-1:0]   val_first = '0;
    logic [COUNT_W-1:0] n_attrs = '0;
    t_scan_res          due_results[$];

    initial begin
        o_fail_count = 0;
        o_waiting = 0;
    end

    task automatic scan_byte(input logic [7:0] c, input logic [POS_W-1:0] p,
                             input logic [POS_W-1:0] te, input logic f);
        t_scan_res  r;
        logic       used;
        logic [POS_W:0] nxt;
        r = '0;
        r.kind = K_PENDING;
        used = 1'b0;
        nxt = {1'b0, p} + (POS_W+1)'(1);
        if (f) begin
            n_attrs = '0;
            st = ST_BETWEEN;
        end
        case (st)
            ST_BETWEEN: begin
                if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                    used = 1'b1;
                end else if (c == CH_GT || (c == CH_SLASH && nxt == {1'b0, te})) begin
                    r.kind = K_DONE;
                    st = ST_IDLE;
                end else begin
                    nm_first = p;
                    nm_last = p;
                    st = (c == CH_EQ) ? ST_QUOTE : ST_NAME;
                    used = 1'b1;
                end
            end
            ST_NAME: begin
                if (c == CH_EQ) begin
                    st = ST_QUOTE;
                end else begin
                    nm_last = p;
                end
                used = 1'b1;
            end
            ST_QUOTE: begin
                if (c == CH_QUOT || c == CH_APOS) begin
                    quote_single = (c == CH_APOS);
                    val_first = p;
                    st = ST_VALUE;
                    used = 1'b1;
                end else begin
                    r.kind = K_NOQUOTE;
                    r.err_offset = {1'b0, p};
                    st = ST_IDLE;
                end
            end
            ST_VALUE: begin
                if (c == (quote_single ? CH_APOS : CH_QUOT)) begin
                    r.kind = K_ATTR;
                    r.name_first = nm_first;
                    r.name_last = nm_last;
                    r.value_first = val_first;
                    r.value_last = p;
                    if (n_attrs < COUNT_LIMIT) begin
                        n_attrs = n_attrs + COUNT_W'(1);
                    end
                    st = ST_BETWEEN;
                end
                used = 1'b1;
            end
            default: begin
                st = ST_IDLE;
            end
        endcase
        if (used && nxt > {1'b0, te}) begin
            r = '0;
            r.kind = K_UNTERM;
            r.err_offset = nxt;
            st = ST_IDLE;
        end
        r.attr_count = n_attrs;
        due_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_scan_res want;
        if (!i_rst_n) begin
            st = ST_IDLE;
            quote_single = 1'b0;
            nm_first = '0;
            nm_last = '0;
            val_first = '0;
            n_attrs = '0;
            due_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_ch, i_pos, i_tag_end, i_first);
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("kind", int'(want.kind), int'(i_kind));
                    check_field("name_first", int'(want.name_first), int'(i_name_first));
                    check_field("name_last", int'(want.name_last), int'(i_name_last));
                    check_field("value_first", int'(want.value_first), int'(i_value_first));
                    check_field("value_last", int'(want.value_last), int'(i_value_last));
                    check_field("attr_count", int'(want.attr_count), int'(i_attr_count));
                    check_field("err_offset", int'(want.err_offset), int'(i_err_offset));
                end
            end
        end
        o_waiting <= due_results.size();
    end

endmodule

// ===== dv/xml_attribute_list_scanner_tb.sv =====
// Testbench top for the XML attribute list scanner: drives directed and random
// start tag bytes with random idling on both sides and gives the verdict.
// Depends on xmlas_pkg, xml_attribute_list_scanner and xmlas_span_check.
`timescale 1ns / 1ps

module xml_attribute_list_scanner_tb;
    import xmlas_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 700;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         ch = '0;
    logic [POS_W-1:0]   pos = '0;
    logic [POS_W-1:0]   tag_end = '0;
    logic               first = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         kind;
    logic [POS_W-1:0]   name_first;
    logic [POS_W-1:0]   name_last;
    logic [POS_W-1:0]   value_first;
    logic [POS_W-1:0]   value_last;
    logic [COUNT_W-1:0] attr_count;
    logic [POS_W:0]     err_offset;
    int                 fail_count;
    int                 waiting;
    int                 n_sent = 0;
    int                 cycles = 0;
    bit                 steady = 1'b0;

    xml_attribute_list_scanner DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_ch          (ch),
        .i_pos         (pos),
        .i_tag_end     (tag_end),
        .i_first       (first),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (kind),
        .o_name_first  (name_first),
        .o_name_last   (name_last),
        .o_value_first (value_first),
        .o_value_last  (value_last),
        .o_attr_count  (attr_count),
        .o_err_offset  (err_offset)
    );

    xmlas_span_check span_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_ch          (ch),
        .i_pos         (pos),
        .i_tag_end     (tag_end),
        .i_first       (first),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_kind        (kind),
        .i_name_first  (name_first),
        .i_name_last   (name_last),
        .i_value_first (value_first),
        .i_value_last  (value_last),
        .i_attr_count  (attr_count),
        .i_err_offset  (err_offset),
        .o_fail_count  (fail_count),
        .o_waiting     (waiting)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= !steady && ($urandom_range(0, 99) < 27);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] byte_except(input logic [7:0] x);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == x);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic [POS_W-1:0] p,
                             input logic [POS_W-1:0] te, input logic f);
        steady = (n_sent >= 350 && n_sent < 500);
        while (!steady && $urandom_range(0, 99) < 27) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        pos <= p;
        tag_end <= te;
        first <= f;
        do @(posedge clk); while (in_stall);
        n_sent++;
    endtask

    task automatic send_str(input string s, input int base, input int tend);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], 16'(base + i), 16'(tend), i == 0);
        end
    endtask

    task automatic send_tag(input bit long_tag, input bit broken);
        logic [7:0] txt[$];
        int         opens[$];
        logic [7:0] q;
        logic [7:0] c;
        int         n_attr;
        int         base;
        int         tend;
        int         restart;
        n_attr = long_tag ? $urandom_range(65, 70) : $urandom_range(0, 4);
        restart = -1;
        for (int a = 0; a < n_attr; a++) begin
            if (!long_tag) begin
                repeat ($urandom_range(0, 2)) txt.push_back(ws_byte());
            end
            if (long_tag || $urandom_range(0, 3) == 0) begin
                txt.push_back(CH_EQ);
            end else begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF ||
                       c == CH_GT || c == CH_SLASH || c == CH_EQ);
                txt.push_back(c);
                repeat ($urandom_range(0, 4)) txt.push_back(byte_except(CH_EQ));
                txt.push_back(CH_EQ);
            end
            q = $urandom_range(0, 1) ? CH_APOS : CH_QUOT;
            opens.push_back(txt.size());
            txt.push_back(q);
            if (!long_tag) begin
                repeat ($urandom_range(0, 5)) txt.push_back(byte_except(q));
            end
            txt.push_back(q);
        end
        repeat ($urandom_range(0, 2)) txt.push_back(ws_byte());
        if ($urandom_range(0, 1)) begin
            txt.push_back(CH_SLASH);
        end
        txt.push_back(CH_GT);
        base = $urandom_range(0, 65536 - txt.size());
        tend = base + txt.size() - 1;
        if (broken) begin
            case ($urandom_range(0, 3))
                0: begin
                    if (opens.size() > 0) begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == CH_QUOT || c == CH_APOS);
                        txt[opens[$urandom_range(0, opens.size() - 1)]] = c;
                    end
                end
                1: begin
                    tend = base + $urandom_range(0, txt.size() - 1);
                end
                2: begin
                    txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                end
                default: begin
                    restart = $urandom_range(1, txt.size() - 1);
                end
            endcase
        end
        for (int i = 0; i < txt.size(); i++) begin
            send_byte(txt[i], 16'(base + i), 16'(tend), i == 0 || i == restart);
        end
    endtask

    initial begin
        int sel;
        int stop_at;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte("a", 16'd5, 16'd9, 1'b0);
        send_str(" \011a=\"v\"\015\012=''/>", 100, 113);
        send_str("b=x", 300, 400);
        send_byte("c", 16'hFFFF, 16'hFFFF, 1'b1);
        send_str("d=\"\"", 200, 203);
        send_byte(8'hFF, 16'h0000, 16'h0000, 1'b1);
        send_byte(CH_GT, 16'hFFFF, 16'h0000, 1'b1);
        send_str("e='x", 500, 600);
        send_byte(CH_GT, 16'd504, 16'd600, 1'b1);

        stop_at = n_sent + RANDOM_ITEMS;
        send_tag(1'b1, 1'b0);
        while (n_sent < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
                end
            end else begin
                send_tag(sel < 13, sel >= 80);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (waiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
